[hw/rtl/kced_pkg.sv]
package kced_pkg;

  // per-key phase, one-hot in the state memory
  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_DEBOUNCE = 5'b00010,
    PH_PRESSED  = 5'b00100,
    PH_LONG     = 5'b01000,
    PH_WAIT     = 5'b10000
  } phase_t;

  // phase codes as reported on the result
  localparam logic [2:0] KP_IDLE     = 3'd0;
  localparam logic [2:0] KP_DEBOUNCE = 3'd1;
  localparam logic [2:0] KP_PRESSED  = 3'd2;
  localparam logic [2:0] KP_LONG     = 3'd3;
  localparam logic [2:0] KP_WAIT     = 3'd4;

  // event codes
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_BOUNCE = 3'd1;
  localparam logic [2:0] EV_SINGLE = 3'd2;
  localparam logic [2:0] EV_DOUBLE = 3'd3;
  localparam logic [2:0] EV_LONG   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_PRESSED_LEVEL = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE      = 2'd1;
  localparam logic [1:0] CFG_DOUBLE_CLICK  = 2'd2;
  localparam logic [1:0] CFG_LONG_PRESS    = 2'd3;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_IDLE:     code = KP_IDLE;
      PH_DEBOUNCE: code = KP_DEBOUNCE;
      PH_PRESSED:  code = KP_PRESSED;
      PH_LONG:     code = KP_LONG;
      PH_WAIT:     code = KP_WAIT;
      default:     code = KP_IDLE;
    endcase
    return code;
  endfunction

endpackage

[hw/rtl/key_click_event_detector_top.sv]
// key click event detector: each request on the input stream is one sampling tick of one
// key (its index and raw pin level); for every request exactly one result request is
// returned, in order, carrying the key's latched event (none, bounce, single, double,
// long), a flag set when the key holds a pending event that this tick latches, and the
// key's new phase. the block takes one tick per clock cycle back to back while results
// are taken, whichever keys they are for; the accepting edge latches the tick and its
// state word out of the per-key state memory in the read stage, and the tick then moves
// on into the result register. a tick for the same key as the one just ahead is served
// by forwarding the freshly computed state, so no bubble is needed. a stalled result
// holds the pipeline without losing anything. the debounce, double-click and long-press
// thresholds and the pressed pin level are for the user to write through the cfg port
// while the block is idle; the block does not enforce this. keys are never cleared by a
// sweep, a per-key valid bit makes an untouched key read as idle with no events.
module key_click_event_detector_top #(
  parameter int NUM_KEYS    = 2,
  parameter int COUNT_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  // input tick stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [0] key_index, [1] pin_level, [7:2] zero
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] latched_event, [3] event_recorded,
                                 // [6:4] key_phase, [7] zero
  // configuration writes
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import kced_pkg::*;

  localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CMP_W  = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

  // one state memory word per key
  typedef struct packed {
    phase_t                 phase;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [2:0]             cur_ev;
    logic [2:0]             rec_ev;
  } entry_t;

  localparam entry_t ENTRY_RST = '{phase: PH_IDLE, cnt: '0, cur_ev: EV_NONE, rec_ev: EV_NONE};

  // configuration registers
  logic       pressed_level_r;
  logic [7:0] debounce_ticks_r;
  logic [7:0] double_click_ticks_r;
  logic [7:0] long_press_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_level_r      <= 1'b0;
      debounce_ticks_r     <= 8'd2;
      double_click_ticks_r <= 8'd30;
      long_press_ticks_r   <= 8'd100;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PRESSED_LEVEL: pressed_level_r      <= cfg_wdata[0];
        CFG_DEBOUNCE:      debounce_ticks_r     <= cfg_wdata;
        CFG_DOUBLE_CLICK:  double_click_ticks_r <= cfg_wdata;
        CFG_LONG_PRESS:    long_press_ticks_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request decode
  logic              in_acc;
  logic [KEY_AW-1:0] in_addr;
  logic              in_inr;

  assign in_acc  = in_tvalid && in_tready;
  assign in_addr = KEY_AW'(in_tdata[0]);
  assign in_inr  = 32'(in_tdata[0]) < NUM_KEYS;

  // read stage: holds the tick while its state word comes out of memory
  logic              s1_valid_r;
  logic [KEY_AW-1:0] s1_addr_r;
  logic              s1_pin_r;
  logic              s1_inr_r;
  entry_t            rd_q_r;
  logic              rd_vld_r;
  logic              byp_r;
  entry_t            byp_data_r;
  logic              s1_move;
  logic              wr_en;
  entry_t            cur;
  entry_t            nxt;
  logic              wrote;

  // result register
  logic       out_valid_r;
  logic [7:0] out_data_r;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign wr_en     = s1_move && s1_inr_r;

  // state memory and its valid bits
  entry_t               mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]  valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr_r] <= nxt;
    end
    if (in_acc) begin
      rd_q_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[s1_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  // tick payload, plus forwarding when the state being written belongs to the new tick
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r  <= in_addr;
      s1_pin_r   <= in_tdata[1];
      s1_inr_r   <= in_inr;
      rd_vld_r   <= valid_r[in_addr];
      byp_r      <= wr_en && (s1_addr_r == in_addr);
      byp_data_r <= nxt;
    end
  end

  // current state of the key: forwarded, stored, or reset value if never written
  always_comb begin
    if (byp_r) begin
      cur = byp_data_r;
    end else if (rd_vld_r) begin
      cur = rd_q_r;
    end else begin
      cur = ENTRY_RST;
    end
  end

  // per-key phase update
  logic                   pr;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CMP_W-1:0]       inc_ext;
  logic [CMP_W-1:0]       deb_ext;
  logic [CMP_W-1:0]       dbl_ext;
  logic [CMP_W-1:0]       lng_ext;
  logic [CMP_W-1:0]       cnt_ext;

  assign pr      = s1_pin_r == pressed_level_r;
  assign cnt_inc = cur.cnt + COUNT_WIDTH'(1);
  assign inc_ext = CMP_W'(cnt_inc);
  assign cnt_ext = CMP_W'(cur.cnt);
  assign deb_ext = CMP_W'(debounce_ticks_r);
  assign dbl_ext = CMP_W'(double_click_ticks_r);
  assign lng_ext = CMP_W'(long_press_ticks_r);

  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      PH_IDLE: begin
        if (pr) begin
          nxt.phase = PH_DEBOUNCE;
          nxt.cnt   = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (pr) begin
          nxt.cnt = cnt_inc;
          if (inc_ext >= deb_ext) begin
            nxt.phase  = PH_PRESSED;
            nxt.cur_ev = EV_NONE;
          end
        end else begin
          // a press that never settled counts as a bounce, unless its count is still zero
          if (cur.cnt != '0) begin
            nxt.cur_ev = EV_BOUNCE;
          end
          nxt.phase = PH_IDLE;
          nxt.cnt   = '0;
        end
      end
      PH_PRESSED: begin
        if (!pr) begin
          if (cnt_ext < dbl_ext) begin
            nxt.phase = PH_WAIT;
          end else begin
            nxt.phase  = PH_IDLE;
            nxt.cur_ev = EV_SINGLE;
          end
          nxt.cnt = '0;
        end else begin
          nxt.cnt = cnt_inc;
          if (inc_ext >= lng_ext) begin
            nxt.phase  = PH_LONG;
            nxt.cur_ev = EV_LONG;
          end
        end
      end
      PH_LONG: begin
        if (!pr) begin
          nxt.phase  = PH_IDLE;
          nxt.cur_ev = EV_NONE;
        end
      end
      PH_WAIT: begin
        // the count carries over into debounce on a second press
        nxt.cnt = cnt_inc;
        if (inc_ext >= dbl_ext) begin
          nxt.phase  = PH_IDLE;
          nxt.cur_ev = EV_SINGLE;
        end else if (pr) begin
          nxt.phase  = PH_DEBOUNCE;
          nxt.cur_ev = EV_DOUBLE;
        end
      end
      default: ;
    endcase
    // any pending event becomes the key's latched event
    wrote = nxt.cur_ev != EV_NONE;
    if (wrote) begin
      nxt.rec_ev = nxt.cur_ev;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      if (s1_inr_r) begin
        out_data_r <= {1'b0, phase_code(nxt.phase), wrote, nxt.rec_ev};
      end else begin
        // a key beyond the configured count leaves nothing changed and reports zero
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  // a tick leaving the read stage always lands in the result register
  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("tick lost between read stage and result register");

  // the state word used for an in-range key is always a legal one-hot phase
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_inr_r) |-> $onehot(cur.phase))
    else $error("corrupt phase in state word");

  // a recorded event is never reported as none
  a_recorded_not_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r[3] || (out_data_r[2:0] != EV_NONE)))
    else $error("event flagged as recorded but latched event is none");
`endif

endmodule
